/* rtl/serial_servo_command_parser_defines.svh */
// assertion macros shared by the servo command parser rtl
`ifndef SERIAL_SERVO_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_SERVO_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRVP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo parser assertion failed");

// next-cycle implication, checked outside reset
`define SRVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo parser assertion failed");

`endif

/* rtl/srvp_pkg.sv */
// types, character codes and compare tables of the servo command parser
package srvp_pkg;

   typedef enum logic [1:0] {
      STAT_NONE  = 2'd0,
      STAT_SERVO = 2'd1,
      STAT_HELP  = 2'd2,
      STAT_ERROR = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_SPACE  = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       echo_valid;
      logic       line_done;
      status_type status;
      logic [1:0] servo_index;
      logic [7:0] angle;
   } judge_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_VT     = 8'h0b;
   localparam logic [7:0] CHAR_FF     = 8'h0c;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SP     = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_1      = 8'h31;
   localparam logic [7:0] CHAR_4      = 8'h34;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_EQ     = 8'h3d;
   localparam logic [7:0] CHAR_UP_E   = 8'h45;
   localparam logic [7:0] CHAR_UP_H   = 8'h48;
   localparam logic [7:0] CHAR_UP_L   = 8'h4c;
   localparam logic [7:0] CHAR_UP_P   = 8'h50;
   localparam logic [7:0] CHAR_UP_S   = 8'h53;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int         ANGLE_MAX   = 180;
   localparam logic [7:0] ANGLE_LIMIT = 8'(ANGLE_MAX);

   localparam int WIDE_BASE   = 2000;
   localparam int WIDE_SPAN   = 3250;
   localparam int NARROW_BASE = 20;
   localparam int NARROW_SPAN = 35;

   typedef logic [12:0] cmp_table_type [256];

   // expected character of the help keyword at a line position
   function automatic logic [7:0] help_char(input logic [1:0] pos);
      logic [7:0] c;
      unique case (pos)
         2'd0:    c = CHAR_UP_H;
         2'd1:    c = CHAR_UP_E;
         2'd2:    c = CHAR_UP_L;
         default: c = CHAR_UP_P;
      endcase
      return c;
   endfunction

   // compare value for every clamped angle, evaluated at elaboration
   function automatic cmp_table_type build_cmp_table(input int base, input int span);
      cmp_table_type t;
      int            a;
      for (int i = 0; i < 256; i++) begin
         a    = (i > ANGLE_MAX) ? ANGLE_MAX : i;
         t[i] = 13'(base + (a * span) / ANGLE_MAX);
      end
      return t;
   endfunction

   localparam cmp_table_type WIDE_CMP   = build_cmp_table(WIDE_BASE, WIDE_SPAN);
   localparam cmp_table_type NARROW_CMP = build_cmp_table(NARROW_BASE, NARROW_SPAN);

endpackage

/* rtl/srvp_line.sv */
// per-line parse state: keyword and prefix match, atoi-style number, line judgment
module srvp_line #(
   parameter int LINE_CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          rx_char,
   output srvp_pkg::judge_type judge
);
   import srvp_pkg::*;

   `include "serial_servo_command_parser_defines.svh"

   localparam int CNT_W = $clog2(LINE_CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ended_ff, ended_in;
   logic             help_ff, help_in;
   logic             prefix_ff, prefix_in;
   logic [1:0]       servo_ff, servo_in;
   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [7:0]       low_ff, low_in;

   logic       is_eol;
   logic [7:0] upper;
   logic       has_room;
   logic       now_ended;
   logic       is_digit;
   logic       is_space;
   logic       is_sign;
   logic [7:0] digit_val;
   logic [7:0] a_raw;
   logic [7:0] a_clamped;
   logic       long_enough;
   status_type status;

   assign is_eol    = (rx_char == CHAR_CR) || (rx_char == CHAR_LF);
   assign upper     = ((rx_char >= CHAR_LOW_A) && (rx_char <= CHAR_LOW_Z)) ?
                      (rx_char - CASE_OFFSET) : rx_char;
   assign has_room  = count_ff < CNT_W'(LINE_CAPACITY - 1);
   assign now_ended = ended_ff || (upper == CHAR_NUL);
   assign is_digit  = (upper >= CHAR_0) && (upper <= CHAR_9);
   assign is_space  = (upper == CHAR_SP) || (upper == CHAR_TAB) ||
                      (upper == CHAR_VT) || (upper == CHAR_FF);
   assign is_sign   = (upper == CHAR_PLUS) || (upper == CHAR_MINUS);
   assign digit_val = upper - CHAR_0;

   always_comb begin
      count_in  = count_ff;
      ended_in  = ended_ff;
      help_in   = help_ff;
      prefix_in = prefix_ff;
      servo_in  = servo_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      low_in    = low_ff;
      if (advance) begin
         if (is_eol) begin
            count_in  = '0;
            ended_in  = 1'b0;
            help_in   = 1'b1;
            prefix_in = 1'b1;
            servo_in  = 2'd0;
            phase_in  = PH_SPACE;
            neg_in    = 1'b0;
            low_in    = 8'd0;
         end else if (has_room) begin
            count_in = count_ff + CNT_W'(1);
            ended_in = now_ended;
            if (now_ended) begin
               if (count_ff < CNT_W'(4)) begin
                  help_in   = 1'b0;
                  prefix_in = 1'b0;
               end
               phase_in = PH_DONE;
            end else begin
               if (count_ff < CNT_W'(4)) begin
                  if (upper != help_char(count_ff[1:0])) begin
                     help_in = 1'b0;
                  end
               end else begin
                  help_in = 1'b0;
               end
               if ((count_ff == CNT_W'(0)) && (upper != CHAR_UP_S)) begin
                  prefix_in = 1'b0;
               end
               if (count_ff == CNT_W'(1)) begin
                  if ((upper >= CHAR_1) && (upper <= CHAR_4)) begin
                     servo_in = 2'(upper - CHAR_1);
                  end else begin
                     prefix_in = 1'b0;
                  end
               end
               if ((count_ff == CNT_W'(2)) && (upper != CHAR_EQ)) begin
                  prefix_in = 1'b0;
               end
               // number after the '=' sign
               if (count_ff >= CNT_W'(3)) begin
                  unique case (phase_ff) inside
                     PH_SPACE: begin
                        if (is_space) begin
                           phase_in = PH_SPACE;
                        end else if (is_sign) begin
                           neg_in   = (upper == CHAR_MINUS);
                           phase_in = PH_SIGN;
                        end else if (is_digit) begin
                           low_in   = 8'(low_ff * 8'd10 + digit_val);
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_SIGN, PH_DIGITS: begin
                        if (is_digit) begin
                           low_in   = 8'(low_ff * 8'd10 + digit_val);
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: phase_in = PH_DONE;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ended_ff  <= 1'b0;
         help_ff   <= 1'b1;
         prefix_ff <= 1'b1;
         servo_ff  <= 2'd0;
         phase_ff  <= PH_SPACE;
         neg_ff    <= 1'b0;
         low_ff    <= 8'd0;
      end else begin
         count_ff  <= count_in;
         ended_ff  <= ended_in;
         help_ff   <= help_in;
         prefix_ff <= prefix_in;
         servo_ff  <= servo_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         low_ff    <= low_in;
      end
   end

   // judgment of the line ended by this byte
   assign a_raw       = neg_ff ? (8'd0 - low_ff) : low_ff;
   assign a_clamped   = (a_raw > ANGLE_LIMIT) ? ANGLE_LIMIT : a_raw;
   assign long_enough = count_ff >= CNT_W'(4);

   always_comb begin
      if (!is_eol || (count_ff == '0)) begin
         status = STAT_NONE;
      end else if (help_ff && long_enough) begin
         status = STAT_HELP;
      end else if (prefix_ff && long_enough) begin
         status = STAT_SERVO;
      end else begin
         status = STAT_ERROR;
      end
   end

   assign judge.echo_valid  = !is_eol;
   assign judge.line_done   = is_eol && (count_ff != '0);
   assign judge.status      = status;
   assign judge.servo_index = (status == STAT_SERVO) ? servo_ff : 2'd0;
   assign judge.angle       = (status == STAT_SERVO) ? a_clamped : 8'd0;

   `SRVP_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(LINE_CAPACITY - 1))
   `SRVP_ASSERT_NEXT(a_eol_clears_line, clock, reset, advance && is_eol,
      (count_ff == '0) && help_ff && prefix_ff && (phase_ff == PH_SPACE))

endmodule

/* rtl/serial_servo_command_parser.sv */
// Serial servo command parser. One result beat leaves for every received byte, in order.
// A byte accepted on req_ is held in an input register, judged against the line state,
// and its result is registered on rsp_ in the output register: throughput is one byte per clock
// while rsp_ does not stall, set by these two register stages with the line state
// updated as the byte leaves the input register. A stalled rsp_ side fills the output
// register and then the input register before req_stall rises. CR or LF ends a line;
// a non-empty line reports help, a servo setting with its compare value, or an error.
module serial_servo_command_parser #(
   parameter int LINE_CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_echo_valid,
   output logic [7:0]  rsp_echo_char,
   output logic        rsp_line_done,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_servo_index,
   output logic [7:0]  rsp_angle,
   output logic [12:0] rsp_compare_value
);
   import srvp_pkg::*;

   `include "serial_servo_command_parser_defines.svh"

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_char_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_echo_valid_ff;
   logic [7:0]  out_echo_char_ff;
   logic        out_line_done_ff;
   logic [1:0]  out_status_ff;
   logic [1:0]  out_servo_ff;
   logic [7:0]  out_angle_ff;
   logic [12:0] out_cmp_ff;

   logic        out_ready;
   logic        advance;
   logic        take;
   judge_type   judge;
   logic [12:0] cmp_value;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;

   assign s1_valid_in  = take || (s1_valid_ff && !out_ready);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   srvp_line #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_line (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .rx_char(s1_char_ff),
      .judge  (judge)
   );

   // servos 1 and 2 use the wide pulse range, 3 and 4 the narrow one
   always_comb begin
      if (judge.status != STAT_SERVO) begin
         cmp_value = 13'd0;
      end else if (judge.servo_index[1]) begin
         cmp_value = NARROW_CMP[judge.angle];
      end else begin
         cmp_value = WIDE_CMP[judge.angle];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_char_ff <= req_rx_char;
      end
      if (advance) begin
         out_echo_valid_ff <= judge.echo_valid;
         out_echo_char_ff  <= judge.echo_valid ? s1_char_ff : 8'd0;
         out_line_done_ff  <= judge.line_done;
         out_status_ff     <= judge.status;
         out_servo_ff      <= judge.servo_index;
         out_angle_ff      <= judge.angle;
         out_cmp_ff        <= cmp_value;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_echo_valid    = out_echo_valid_ff;
   assign rsp_echo_char     = out_echo_char_ff;
   assign rsp_line_done     = out_line_done_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_servo_index   = out_servo_ff;
   assign rsp_angle         = out_angle_ff;
   assign rsp_compare_value = out_cmp_ff;

   `SRVP_ASSERT_NOW(a_stall_needs_beat, clock, reset, req_stall, s1_valid_ff && out_valid_ff)
   `SRVP_ASSERT_NOW(a_done_not_echoed, clock, reset, rsp_valid && rsp_line_done,
      !rsp_echo_valid && (rsp_status != STAT_NONE))
   `SRVP_ASSERT_NOW(a_servo_cmp_range, clock, reset, rsp_valid && (rsp_status == STAT_SERVO),
      (rsp_compare_value >= 13'd20) && (rsp_compare_value <= 13'd5250) &&
      (rsp_angle <= ANGLE_LIMIT))
   `SRVP_ASSERT_NOW(a_idle_fields_zero, clock, reset, rsp_valid && (rsp_status != STAT_SERVO),
      (rsp_compare_value == 13'd0) && (rsp_angle == 8'd0) && (rsp_servo_index == 2'd0))

endmodule
